// ----- src/mjji_pkg.sv -----
// Shared constants and types for the minimum-jerk joint interpolator.
// No dependencies; imported by mjji_mul and the top level.
package mjji_pkg;

  // item fields
  localparam int JOINTS    = 8;               // joints driven
  localparam int NUM_LANES = 8;               // joint lanes carried on the stream
  localparam int POS_BITS  = 16;              // signed Q2.13 angle
  localparam int DATA_W    = NUM_LANES * POS_BITS;
  localparam int STEP_W    = 10;              // step counter and step count
  localparam int DIFF_W    = POS_BITS + 1;    // goal minus start
  localparam int JW        = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // blend factor: unsigned Q1.30
  localparam int SFRAC  = 30;
  localparam int QUO_W  = SFRAC + 1;
  localparam int CNT_W  = 5;
  localparam int RAT_W  = 50;                 // numerator and N^5
  localparam int POLY_W = 25;

  // shared multiplier
  localparam int MA_W = 41;
  localparam int MB_W = 25;
  localparam int P_W  = MA_W + MB_W;

  // item kinds on tuser[0]
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // configuration register indexes
  localparam logic REG_TRANSITION = 1'b0;
  localparam logic REG_CLOSING    = 1'b1;

  localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(100);

  typedef struct packed {
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
  } mul_op_t;

endpackage

// ----- src/mjji_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on mjji_pkg for operand widths and the operand struct.
module mjji_mul
  import mjji_pkg::*;
(
  input  logic                  clk,
  input  mul_op_t               op,
  output logic signed [P_W-1:0] p
);

  // one product per cycle, no reset on the datapath
  always_ff @(posedge clk) begin
    p <= op.a * op.b;
  end

endmodule

// ----- src/minimum_jerk_joint_interpolator_unit.sv -----
// Top level of the minimum-jerk joint interpolator: sequencer, posture store,
// restoring divider and output register. Depends on mjji_pkg and mjji_mul.
//
// A begin beat (tuser[0] = 0) gives no output unless the selected step count is
// zero, in which case the target goes to the output register with tlast set. A
// tick beat (tuser[0] = 1) that ends a move gives the goal posture with tlast.
// Any other tick beat during a move runs eight passes through the shared
// multiplier to form the blend numerator and N^5, a divider load, a 31-step
// restoring division for the Q1.30 blend factor, then a multiply state and an
// accumulate state per joint on the same multiplier, and an emit state that
// moves the point into the output register once it is free. s_axis_tready
// is high only while the sequencer is idle; a finished point may wait in the
// output register while the next beat is taken. Ticks outside a move are
// dropped. Configuration writes are always taken.
module minimum_jerk_joint_interpolator_unit
  import mjji_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // slave stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // target_j0 .. target_j7, 16 bits each
  input  logic [1:0]        s_axis_tuser,   // mode, use_closing_time
  // master stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // pos_j0 .. pos_j7, 16 bits each
  output logic              m_axis_tlast,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [STEP_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PA, ST_PB, ST_PC, ST_PD, ST_PE, ST_PF, ST_PG, ST_PH,
    ST_DLD, ST_DIV, ST_JMUL, ST_JACC, ST_EMIT
  } state_t;

  localparam logic [P_W-1:0] RND_HALF = {{(P_W-SFRAC){1'b0}}, 1'b1, {(SFRAC-1){1'b0}}};

  state_t state;

  logic [STEP_W-1:0] transition_steps;
  logic [STEP_W-1:0] closing_steps;

  logic signed [POS_BITS-1:0] start_pos [JOINTS];
  logic signed [POS_BITS-1:0] goal_pos  [JOINTS];
  logic signed [POS_BITS-1:0] res_pos   [JOINTS];
  logic signed [POS_BITS-1:0] out_pos   [JOINTS];
  logic                       res_last;
  logic                       moving;
  logic [STEP_W-1:0]          k;
  logic [STEP_W-1:0]          n_reg;

  logic signed [POLY_W-1:0] poly;
  logic [RAT_W-1:0]         num;
  logic [RAT_W-1:0]         den;
  logic [RAT_W:0]           rem;
  logic [QUO_W-1:0]         quo;
  logic [CNT_W-1:0]         cnt;
  logic [JW-1:0]            jidx;

  mul_op_t               op;
  logic signed [P_W-1:0] p;

  logic signed [POS_BITS-1:0] target [JOINTS];
  logic [STEP_W-1:0]          sel_n;
  logic [STEP_W-1:0]          tick_k;
  logic                       accept;
  logic [15:0]                ten_n;
  logic [15:0]                fifteen_k;
  logic [15:0]                lin;
  logic [15:0]                six_k;
  logic signed [POS_BITS-1:0] start_sel;
  logic signed [POS_BITS-1:0] goal_sel;
  logic signed [DIFF_W-1:0]   diff;
  logic [RAT_W:0]             trial;
  logic                       ge;
  logic signed [P_W-1:0]      rnd;
  logic signed [P_W-1:0]      scaled;
  logic signed [POS_BITS-1:0] blend_pos;

  mjji_mul u_mul (
    .clk (clk),
    .op  (op),
    .p   (p)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // unpack targets, pack output lanes
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      target[j] = s_axis_tdata[j*POS_BITS +: POS_BITS];
    end
    m_axis_tdata = '0;
    for (int j = 0; j < JOINTS; j++) begin
      m_axis_tdata[j*POS_BITS +: POS_BITS] = out_pos[j];
    end
  end

  // step count selection and tick advance
  assign sel_n  = s_axis_tuser[1] ? closing_steps : transition_steps;
  assign tick_k = k + STEP_W'(1);

  // linear terms of the blend polynomial: 10N - 15k and 6k
  assign ten_n     = ({6'b0, n_reg} << 3) + ({6'b0, n_reg} << 1);
  assign fifteen_k = ({6'b0, k} << 4) - {6'b0, k};
  assign lin       = ten_n - fifteen_k;
  assign six_k     = ({6'b0, k} << 2) + ({6'b0, k} << 1);

  // per-joint operands and rounding
  assign start_sel = start_pos[jidx];
  assign goal_sel  = goal_pos[jidx];
  assign diff      = {goal_sel[POS_BITS-1], goal_sel} - {start_sel[POS_BITS-1], start_sel};
  assign rnd       = p + signed'(RND_HALF);
  assign scaled    = rnd >>> SFRAC;
  assign blend_pos = start_sel + scaled[POS_BITS-1:0];

  // divider step: the first step compares without a shift
  assign trial = (cnt == CNT_W'(SFRAC)) ? rem : {rem[RAT_W-1:0], 1'b0};
  assign ge    = (trial >= {1'b0, den});

  // shared multiplier operand selection
  always_comb begin
    op.a = '0;
    op.b = '0;
    unique case (state)
      ST_PA: begin
        op.a = {{(MA_W-STEP_W){1'b0}}, n_reg};
        op.b = {{(MB_W-16){lin[15]}}, lin};
      end
      ST_PB: begin
        op.a = {{(MA_W-STEP_W){1'b0}}, k};
        op.b = {{(MB_W-16){1'b0}}, six_k};
      end
      ST_PC: begin
        op.a = {{(MA_W-STEP_W){1'b0}}, k};
        op.b = {{(MB_W-STEP_W){1'b0}}, k};
      end
      ST_PD: begin
        op.a = p[MA_W-1:0];
        op.b = {{(MB_W-STEP_W){1'b0}}, k};
      end
      ST_PE: begin
        op.a = p[MA_W-1:0];
        op.b = poly;
      end
      ST_PF: begin
        op.a = {{(MA_W-STEP_W){1'b0}}, n_reg};
        op.b = {{(MB_W-STEP_W){1'b0}}, n_reg};
      end
      ST_PG: begin
        op.a = p[MA_W-1:0];
        op.b = p[MB_W-1:0];
      end
      ST_PH: begin
        op.a = p[MA_W-1:0];
        op.b = {{(MB_W-STEP_W){1'b0}}, n_reg};
      end
      ST_JMUL: begin
        op.a = {{(MA_W-QUO_W){1'b0}}, quo};
        op.b = {{(MB_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      end
      default: begin
        op.a = '0;
        op.b = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      transition_steps <= STEPS_RESET;
      closing_steps    <= STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRANSITION: transition_steps <= cfg_data;
        REG_CLOSING:    closing_steps    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // sequencer, posture store and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      moving        <= 1'b0;
      k             <= '0;
      n_reg         <= '0;
      m_axis_tvalid <= 1'b0;
      for (int j = 0; j < JOINTS; j++) begin
        start_pos[j] <= '0;
        goal_pos[j]  <= '0;
      end
    end else begin
      // output beat taken; a point waiting in emit reloads the register below
      if (m_axis_tvalid && m_axis_tready && (state != ST_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser[0] == MODE_BEGIN) begin
              k     <= '0;
              n_reg <= sel_n;
              for (int j = 0; j < JOINTS; j++) begin
                goal_pos[j] <= target[j];
              end
              if (sel_n == '0) begin
                // zero length: jump straight to the target
                moving   <= 1'b0;
                res_last <= 1'b1;
                for (int j = 0; j < JOINTS; j++) begin
                  start_pos[j] <= target[j];
                  res_pos[j]   <= target[j];
                end
                state <= ST_EMIT;
              end else begin
                moving <= 1'b1;
                for (int j = 0; j < JOINTS; j++) begin
                  start_pos[j] <= goal_pos[j];
                end
              end
            end else if (moving) begin
              if (tick_k >= n_reg) begin
                // final point is the goal itself
                k        <= n_reg;
                moving   <= 1'b0;
                res_last <= 1'b1;
                for (int j = 0; j < JOINTS; j++) begin
                  start_pos[j] <= goal_pos[j];
                  res_pos[j]   <= goal_pos[j];
                end
                state <= ST_EMIT;
              end else begin
                k     <= tick_k;
                state <= ST_PA;
              end
            end
          end
        end
        ST_PA: state <= ST_PB;
        ST_PB: begin
          poly  <= p[POLY_W-1:0];
          state <= ST_PC;
        end
        ST_PC: begin
          poly  <= poly + p[POLY_W-1:0];
          state <= ST_PD;
        end
        ST_PD: state <= ST_PE;
        ST_PE: state <= ST_PF;
        ST_PF: begin
          num   <= p[RAT_W-1:0];
          state <= ST_PG;
        end
        ST_PG: state <= ST_PH;
        ST_PH: state <= ST_DLD;
        ST_DLD: begin
          den   <= p[RAT_W-1:0];
          rem   <= {1'b0, num};
          quo   <= '0;
          cnt   <= CNT_W'(SFRAC);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? (trial - {1'b0, den}) : trial;
          quo <= {quo[QUO_W-2:0], ge};
          if (cnt == '0) begin
            jidx  <= '0;
            state <= ST_JMUL;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_JMUL: state <= ST_JACC;
        ST_JACC: begin
          res_pos[jidx] <= blend_pos;
          if (jidx == JW'(JOINTS - 1)) begin
            res_last <= 1'b0;
            state    <= ST_EMIT;
          end else begin
            jidx  <= jidx + JW'(1);
            state <= ST_JMUL;
          end
        end
        ST_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= res_last;
            for (int j = 0; j < JOINTS; j++) begin
              out_pos[j] <= res_pos[j];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a running move never reaches its own length
  a_step_below_length: assert property (@(posedge clk) disable iff (rst)
    moving |-> (k < n_reg))
    else $error("step counter reached move length while moving");

  // at rest the counter is either cleared or parked at the move length
  a_rest_counter: assert property (@(posedge clk) disable iff (rst)
    !moving |-> ((k == '0) || (k == n_reg)))
    else $error("idle step counter out of place");

  // blend factor of an interior point stays below one
  a_blend_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_JMUL) |-> !quo[QUO_W-1])
    else $error("blend factor reached one on an interior step");

  // the arithmetic runs only for a tick taken during a move
  a_start_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) ##1 (state == ST_PA) |-> $past(s_axis_tuser[0] == MODE_TICK))
    else $error("interpolation started without a tick beat");

endmodule
